@@ hw/rtl/csiu_pkg.sv @@
// Shared types and opcode constants for the system instruction unit.
package csiu_pkg;

  // Exception kinds reported with each result word
  typedef enum logic [2:0] {
    EXC_NONE      = 3'd0,
    EXC_PRIVILEGE = 3'd1,
    EXC_TRAP      = 3'd2,
    EXC_TRAPV     = 3'd3,
    EXC_CHK       = 3'd4,
    EXC_ILLEGAL   = 3'd5,
    EXC_UNKNOWN   = 3'd6
  } exc_kind_t;

  // Exact instruction words
  localparam logic [15:0] OP_NOP     = 16'h4E71;
  localparam logic [15:0] OP_RESET   = 16'h4E70;
  localparam logic [15:0] OP_STOP    = 16'h4E72;
  localparam logic [15:0] OP_ILLEGAL = 16'h4AFC;
  localparam logic [15:0] OP_TRAPV   = 16'h4E76;

  // Pattern/mask pairs for instruction families
  localparam logic [15:0] MASK_VEC   = 16'hFFF0;
  localparam logic [15:0] MASK_EA    = 16'hFFC0;
  localparam logic [15:0] MASK_CHK   = 16'hF1C0;
  localparam logic [15:0] PAT_TRAP   = 16'h4E40;
  localparam logic [15:0] PAT_USP    = 16'h4E60;
  localparam logic [15:0] PAT_CHK    = 16'h4180;
  localparam logic [15:0] PAT_TAS    = 16'h4AC0;
  localparam logic [15:0] PAT_TO_SR  = 16'h46C0;
  localparam logic [15:0] PAT_TO_CCR = 16'h44C0;
  localparam logic [15:0] PAT_FR_SR  = 16'h40C0;

  // Status register fields
  localparam logic [15:0] SR_RESET   = 16'h2700;
  localparam logic [15:0] SR_HI_MASK = 16'hFF00;
  localparam logic [4:0]  CCR_MASK   = 5'h1F;
  localparam logic [7:0]  TAS_MARK   = 8'h80;
  localparam int unsigned SR_S_BIT   = 13;
  localparam int unsigned SR_N_BIT   = 3;
  localparam int unsigned SR_Z_BIT   = 2;
  localparam int unsigned SR_V_BIT   = 1;
  localparam int unsigned SR_C_BIT   = 0;

  // Result of executing one instruction word
  typedef struct packed {
    exc_kind_t   kind;
    logic [3:0]  trap_vector;
    logic        write_enable;
    logic [31:0] write_value;
    logic        leave_supervisor;
    logic        bus_reset;
    logic [7:0]  cycle_count;
  } exec_res_t;

  // Architectural state update produced by the execute logic
  typedef struct packed {
    logic [15:0] sr;
    logic        usp_we;
    logic [31:0] usp;
    logic        stopped;
  } state_upd_t;

endpackage

@@ hw/rtl/csiu_exec.sv @@
// Decode and execute logic for one system-group instruction word.
module csiu_exec
  import csiu_pkg::*;
(
  input  logic               [15:0] cmd,
  input  logic               [15:0] opw,
  input  logic signed        [15:0] dw,
  input  logic               [31:0] an,
  input  logic               [15:0] sr_cur,
  input  logic               [31:0] usp_cur,
  input  logic                      stopped_cur,
  output exec_res_t                 res,
  output state_upd_t                upd
);

  logic       sup;
  logic       mode_dreg;
  logic       is_priv;
  logic [7:0] tas_byte;

  assign sup       = sr_cur[SR_S_BIT];
  assign mode_dreg = (cmd[5:3] == 3'd0);
  assign tas_byte  = opw[7:0];
  assign is_priv   = (cmd inside {OP_RESET, OP_STOP}) ||
                     ((cmd & MASK_EA) == PAT_TO_SR) ||
                     ((cmd & MASK_VEC) == PAT_USP);

  // Priority decode, privilege check first
  always_comb begin
    res              = '0;
    res.kind         = EXC_NONE;
    upd.sr           = sr_cur;
    upd.usp_we       = 1'b0;
    upd.usp          = an;
    upd.stopped      = stopped_cur;

    if (is_priv && !sup) begin
      res.kind = EXC_PRIVILEGE;
    end else if (cmd == OP_NOP) begin
      res.cycle_count = 8'd4;
    end else if (cmd == OP_RESET) begin
      res.bus_reset   = 1'b1;
      res.cycle_count = 8'd132;
    end else if (cmd == OP_STOP) begin
      upd.sr               = opw;
      res.leave_supervisor = ~opw[SR_S_BIT];
      upd.stopped          = 1'b1;
      res.cycle_count      = 8'd4;
    end else if (cmd == OP_ILLEGAL) begin
      res.kind = EXC_ILLEGAL;
    end else if ((cmd & MASK_VEC) == PAT_TRAP) begin
      res.kind        = EXC_TRAP;
      res.trap_vector = cmd[3:0];
    end else if (cmd == OP_TRAPV) begin
      if (sr_cur[SR_V_BIT]) begin
        res.kind = EXC_TRAPV;
      end else begin
        res.cycle_count = 8'd4;
      end
    end else if ((cmd & MASK_CHK) == PAT_CHK) begin
      // Bounds check 0 <= Dn <= operand, signed
      if (dw[15]) begin
        upd.sr[SR_N_BIT] = 1'b1;
        res.kind         = EXC_CHK;
      end else if (dw > $signed(opw)) begin
        upd.sr[SR_N_BIT] = 1'b0;
        res.kind         = EXC_CHK;
      end else begin
        res.cycle_count = 8'd10;
      end
    end else if ((cmd & MASK_EA) == PAT_FR_SR) begin
      res.write_enable = 1'b1;
      res.write_value  = {16'd0, sr_cur};
      res.cycle_count  = mode_dreg ? 8'd6 : 8'd8;
    end else if ((cmd & MASK_EA) == PAT_TO_SR) begin
      upd.sr               = opw;
      res.leave_supervisor = ~opw[SR_S_BIT];
      res.cycle_count      = 8'd12;
    end else if ((cmd & MASK_EA) == PAT_TO_CCR) begin
      upd.sr          = (sr_cur & SR_HI_MASK) | {11'd0, opw[4:0] & CCR_MASK};
      res.cycle_count = 8'd12;
    end else if ((cmd & MASK_VEC) == PAT_USP) begin
      // Bit 3 picks direction: clear = An to USP
      if (!cmd[3]) begin
        upd.usp_we = 1'b1;
      end else begin
        res.write_enable = 1'b1;
        res.write_value  = usp_cur;
      end
      res.cycle_count = 8'd4;
    end else if ((cmd & MASK_EA) == PAT_TAS) begin
      upd.sr[SR_N_BIT] = tas_byte[7];
      upd.sr[SR_Z_BIT] = (tas_byte == 8'd0);
      upd.sr[SR_V_BIT] = 1'b0;
      upd.sr[SR_C_BIT] = 1'b0;
      res.write_enable = 1'b1;
      res.write_value  = {24'd0, tas_byte | TAS_MARK};
      res.cycle_count  = mode_dreg ? 8'd4 : 8'd14;
    end else begin
      res.kind = EXC_UNKNOWN;
    end
  end

endmodule

@@ hw/rtl/cpu_system_instruction_unit.sv @@
// Top level of the system instruction unit: word registers, state and result register.
//
// Executes one system-group instruction word per input word and returns one
// result word for it. The input channel (in_*) carries the instruction, the
// fetched operand, the CHK data register low word and an address register.
// The result channel (out_*) carries the exception kind in tuser and the
// trap vector, write-back, new status word, halted, supervisor-exit,
// bus-reset and base cycle count fields in tdata.
// A word accepted into the input register is executed combinationally and moves
// into the result register, which drives out_*, once that register is free or being drained.
// Throughput: one word per cycle while out_tready stays high; decode, a single signed
// 16-bit compare and the status masking sit between the input and result registers.
// State (status register, user stack pointer, stopped flag) is updated as a
// word moves into the result register, so the next word sees it at once.
// Reset loads the status register with 0x2700, clears USP and the stopped
// flag and empties both registers. When the receiver stalls the result word
// holds; the input register still takes one more word, then in_tready drops.
module cpu_system_instruction_unit
  import csiu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] command, [31:16] operand_word, [47:32] data_reg_word,
  // [79:48] address_reg_value
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] trap_vector, [4] write_enable, [36:5] write_value,
  // [52:37] status_word, [53] halted, [54] leave_supervisor,
  // [55] bus_reset, [63:56] cycle_count
  output logic [63:0] out_tdata,
  // [2:0] exception_kind
  output logic [2:0]  out_tuser
);

  logic        s1_v_r, s1_v_nxt;
  logic [15:0] cmd_r;
  logic [15:0] opw_r;
  logic signed [15:0] dw_r;
  logic [31:0] an_r;
  logic        out_v_r, out_v_nxt;
  logic [63:0] out_data_r;
  logic [2:0]  out_user_r;
  logic [15:0] sr_r;
  logic [31:0] usp_r;
  logic        stopped_r;
  logic        adv;
  logic        in_acc;
  exec_res_t   res;
  state_upd_t  upd;

  // Handshake: execute when the result register is free or being drained
  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_v_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  // Execute logic
  csiu_exec u_exec (
    .cmd        (cmd_r),
    .opw        (opw_r),
    .dw         (dw_r),
    .an         (an_r),
    .sr_cur     (sr_r),
    .usp_cur    (usp_r),
    .stopped_cur(stopped_r),
    .res        (res),
    .upd        (upd)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      sr_r      <= SR_RESET;
      usp_r     <= 32'd0;
      stopped_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        sr_r      <= upd.sr;
        stopped_r <= upd.stopped;
        if (upd.usp_we) begin
          usp_r <= upd.usp;
        end
      end
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tdata[15:0];
      opw_r <= in_tdata[31:16];
      dw_r  <= $signed(in_tdata[47:32]);
      an_r  <= in_tdata[79:48];
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_user_r <= res.kind;
      out_data_r <= {res.cycle_count, res.bus_reset, res.leave_supervisor,
                     upd.stopped, upd.sr, res.write_value, res.write_enable,
                     res.trap_vector};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Once stopped, the flag stays set until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");

  // Exceptions report zero base cycles
  a_exc_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_user_r != EXC_NONE) |-> (out_data_r[63:56] == 8'd0))
    else $error("nonzero cycle count on exception");

  // Reported status word matches the committed status register
  a_sr_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_data_r[52:37] == sr_r))
    else $error("status word does not match status register");

  // An empty input register always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_tready)
    else $error("input stalled while input register empty");

endmodule

@@ verif/cpu_system_instruction_unit_tb.sv @@
// Self-checking testbench for the system instruction unit: directed and random words, scoreboard.
module cpu_system_instruction_unit_tb;
  import csiu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  // One expected result word, unpacked
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  vec;
    logic        we;
    logic [31:0] wv;
    logic [15:0] sr;
    logic        halted;
    logic        leave;
    logic        bus_rst;
    logic [7:0]  cycles;
  } exec_result_t;

  // Shadow of SR/USP/stopped plus the queue of predicted result words
  class exec_scoreboard;
    logic [15:0]  sr;
    logic [31:0]  usp;
    logic         stopped;
    exec_result_t expected_results[$];
    int           errors;
    int           issued;
    int           checked;
    int           kind_hits[8];

    function new();
      sr = SR_RESET;
      usp = '0;
      stopped = 1'b0;
      errors = 0;
      issued = 0;
      checked = 0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Execute one accepted instruction word on the shadow state
    function void note_instruction(logic [79:0] word);
      logic [15:0]        cmd;
      logic [15:0]        opw;
      logic signed [15:0] data_s;
      logic signed [15:0] bound_s;
      logic [31:0]        an;
      logic [7:0]         tas_byte;
      logic               sup;
      logic               dreg_mode;
      logic               priv;
      exec_result_t       r;
      cmd = word[15:0];
      opw = word[31:16];
      data_s = word[47:32];
      bound_s = word[31:16];
      an = word[79:48];
      sup = sr[SR_S_BIT];
      dreg_mode = (cmd[5:3] == 3'd0);
      priv = (cmd == OP_RESET) || (cmd == OP_STOP) ||
             ((cmd & MASK_EA) == PAT_TO_SR) || ((cmd & MASK_VEC) == PAT_USP);
      r = '{default: '0};
      if (priv && !sup) begin
        r.kind = EXC_PRIVILEGE;
      end else if (cmd == OP_NOP) begin
        r.cycles = 8'd4;
      end else if (cmd == OP_RESET) begin
        r.bus_rst = 1'b1;
        r.cycles = 8'd132;
      end else if (cmd == OP_STOP) begin
        sr = opw;
        r.leave = !opw[SR_S_BIT];
        stopped = 1'b1;
        r.cycles = 8'd4;
      end else if (cmd == OP_ILLEGAL) begin
        r.kind = EXC_ILLEGAL;
      end else if ((cmd & MASK_VEC) == PAT_TRAP) begin
        r.kind = EXC_TRAP;
        r.vec = cmd[3:0];
      end else if (cmd == OP_TRAPV) begin
        if (sr[SR_V_BIT]) r.kind = EXC_TRAPV;
        else r.cycles = 8'd4;
      end else if ((cmd & MASK_CHK) == PAT_CHK) begin
        // below zero sets N, above the bound clears it
        if (data_s < 0) begin
          sr[SR_N_BIT] = 1'b1;
          r.kind = EXC_CHK;
        end else if (data_s > bound_s) begin
          sr[SR_N_BIT] = 1'b0;
          r.kind = EXC_CHK;
        end else begin
          r.cycles = 8'd10;
        end
      end else if ((cmd & MASK_EA) == PAT_FR_SR) begin
        r.we = 1'b1;
        r.wv = {16'h0000, sr};
        r.cycles = dreg_mode ? 8'd6 : 8'd8;
      end else if ((cmd & MASK_EA) == PAT_TO_SR) begin
        sr = opw;
        r.leave = !opw[SR_S_BIT];
        r.cycles = 8'd12;
      end else if ((cmd & MASK_EA) == PAT_TO_CCR) begin
        sr = (sr & SR_HI_MASK) | {11'd0, opw[4:0] & CCR_MASK};
        r.cycles = 8'd12;
      end else if ((cmd & MASK_VEC) == PAT_USP) begin
        if (!cmd[3]) begin
          usp = an;
        end else begin
          r.we = 1'b1;
          r.wv = usp;
        end
        r.cycles = 8'd4;
      end else if ((cmd & MASK_EA) == PAT_TAS) begin
        tas_byte = opw[7:0];
        sr[SR_N_BIT] = tas_byte[7];
        sr[SR_Z_BIT] = (tas_byte == 8'h00);
        sr[SR_V_BIT] = 1'b0;
        sr[SR_C_BIT] = 1'b0;
        r.we = 1'b1;
        r.wv = {24'd0, tas_byte | TAS_MARK};
        r.cycles = dreg_mode ? 8'd4 : 8'd14;
      end else begin
        r.kind = EXC_UNKNOWN;
      end
      r.sr = sr;
      r.halted = stopped;
      expected_results.push_back(r);
      issued++;
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_result_word(logic [63:0] data, logic [2:0] user);
      exec_result_t e;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: tdata 0x%0h tuser 0x%0h", data, user);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      kind_hits[e.kind]++;
      compare_field("exception_kind", 32'(e.kind), 32'(user));
      compare_field("trap_vector", 32'(e.vec), 32'(data[3:0]));
      compare_field("write_enable", 32'(e.we), 32'(data[4]));
      compare_field("write_value", e.wv, data[36:5]);
      compare_field("status_word", 32'(e.sr), 32'(data[52:37]));
      compare_field("halted", 32'(e.halted), 32'(data[53]));
      compare_field("leave_supervisor", 32'(e.leave), 32'(data[54]));
      compare_field("bus_reset", 32'(e.bus_rst), 32'(data[55]));
      compare_field("cycle_count", 32'(e.cycles), 32'(data[63:56]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [15:0] command, [31:16] operand_word, [47:32] data_reg_word,
  // [79:48] address_reg_value
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [3:0] trap_vector, [4] write_enable, [36:5] write_value,
  // [52:37] status_word, [53] halted, [54] leave_supervisor,
  // [55] bus_reset, [63:56] cycle_count
  logic [63:0] out_tdata;
  // [2:0] exception_kind
  logic [2:0]  out_tuser;

  exec_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int idle_cycles;

  cpu_system_instruction_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock, period 2
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result_word(out_tdata, out_tuser);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drive one instruction word; called at a falling edge, returns at one
  task automatic send_word(logic [15:0] cmd, logic [15:0] opw, logic [15:0] dw,
                           logic [31:0] an);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {an, dw, opw, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_instruction(in_tdata);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed group instructions with random fields, some noise
  task automatic random_instr(bit keep_sup, bit allow_stop);
    logic [15:0] cmd;
    logic [15:0] opw;
    logic [15:0] dw;
    logic [31:0] an;
    opw = 16'($urandom);
    dw = 16'($urandom);
    an = $urandom;
    case ($urandom_range(0, 15))
      0: cmd = OP_NOP;
      1: cmd = OP_RESET;
      2: cmd = OP_STOP;
      3: cmd = PAT_TRAP | 16'($urandom_range(0, 15));
      4: cmd = OP_TRAPV;
      5, 6: begin
        cmd = PAT_CHK | 16'($urandom_range(0, 7) << 9) | 16'($urandom_range(0, 63));
        // keep the register near the bound half the time
        if ($urandom_range(0, 1)) begin
          opw = 16'($urandom_range(0, 40));
          dw = 16'(int'($urandom_range(0, 48)) - 8);
        end
      end
      7: cmd = OP_ILLEGAL;
      8: cmd = PAT_FR_SR | 16'($urandom_range(0, 63));
      9: cmd = PAT_TO_SR | 16'($urandom_range(0, 63));
      10: cmd = PAT_TO_CCR | 16'($urandom_range(0, 63));
      11: cmd = PAT_USP | 16'($urandom_range(0, 15));
      12: begin
        cmd = PAT_TAS | 16'($urandom_range(0, 63));
        if ($urandom_range(0, 7) == 0) opw[7:0] = 8'h00;
      end
      default: cmd = 16'($urandom);
    endcase
    if (!allow_stop && cmd == OP_STOP) cmd = OP_NOP;
    // supervisor mode can only be left once, so supervisor phases keep S set
    if (keep_sup && (cmd == OP_STOP || (cmd & MASK_EA) == PAT_TO_SR)) opw[SR_S_BIT] = 1'b1;
    send_word(cmd, opw, dw, an);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    idle_cycles = 0;
    send_idle_pct = 34;
    recv_idle_pct = 66;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every operation but STOP, in supervisor mode, before any STOP
    send_word(OP_NOP, 16'h0000, 16'h0000, 32'h0);
    send_word(OP_RESET, 16'h1234, 16'h0000, 32'h0);
    send_word(PAT_TRAP, 16'h0000, 16'h0000, 32'h0);
    send_word(PAT_TRAP | 16'h000F, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_ILLEGAL, 16'h0000, 16'h0000, 32'h0);
    send_word(OP_TRAPV, 16'h0000, 16'h0000, 32'h0);          // V clear
    send_word(PAT_TO_CCR, 16'hFFFF, 16'h0000, 32'h0);        // only low five bits
    send_word(OP_TRAPV, 16'h0000, 16'h0000, 32'h0);          // V set, taken
    send_word(PAT_CHK, 16'h7FFF, 16'h8000, 32'h0);           // negative register
    send_word(16'h4FBF, 16'h7FFE, 16'h7FFF, 32'h0);          // above bound
    send_word(PAT_CHK, 16'h0000, 16'h0000, 32'h0);           // equal, in range
    send_word(PAT_CHK, 16'hFFFF, 16'h0005, 32'h0);           // bound negative
    send_word(PAT_FR_SR, 16'h0000, 16'h0000, 32'h0);         // data register mode
    send_word(PAT_FR_SR | 16'h003F, 16'h0000, 16'h0000, 32'h0);
    send_word(PAT_TAS, 16'hFF00, 16'h0000, 32'h0);           // zero byte
    send_word(PAT_TAS | 16'h0010, 16'h0080, 16'h0000, 32'h0);
    send_word(PAT_TAS | 16'h0007, 16'h007F, 16'h0000, 32'h0);
    send_word(PAT_USP, 16'h0000, 16'h0000, 32'hFFFF_FFFF);   // An to USP
    send_word(PAT_USP | 16'h000F, 16'h0000, 16'h0000, 32'h0);// USP to An
    send_word(PAT_USP | 16'h0007, 16'h0000, 16'h0000, 32'h0);
    send_word(16'h0000, 16'h0000, 16'h0000, 32'h0);          // outside the group
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(PAT_TO_SR | 16'h003F, 16'hFFFF, 16'h0000, 32'h0); // all 16 bits load
    send_word(PAT_TO_SR, SR_RESET, 16'h0000, 32'h0);

    // Phase 1: sender idles lightly, receiver heavily, not yet stopped
    repeat (620) random_instr(1'b1, 1'b0);
    wait_drained();

    // Phase 2: roles swapped, STOP allowed from here on
    send_idle_pct = 66;
    recv_idle_pct = 34;
    send_word(OP_STOP, 16'hFFFF, 16'h0000, 32'h0);
    repeat (620) random_instr(1'b1, 1'b1);
    wait_drained();

    // Phase 3: full rate, then drop into user mode for the rest
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (500) random_instr(1'b1, 1'b1);
    send_word(PAT_TO_SR, 16'h0000, 16'h0000, 32'h0);         // supervisor exit
    send_word(OP_RESET, 16'h0000, 16'h0000, 32'h0);
    send_word(OP_STOP, 16'h2700, 16'h0000, 32'h0);
    send_word(PAT_TO_SR | 16'h0005, 16'h2700, 16'h0000, 32'h0);
    send_word(PAT_USP | 16'h0008, 16'h0000, 16'h0000, 32'h0);
    repeat (180) random_instr(1'b0, 1'b1);

    // Let everything come back, then a few quiet cycles
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d instruction words, checked %0d result words, %0d mismatches.",
             sb.issued, sb.checked, sb.errors);
    $display("Kinds: none %0d, privilege %0d, trap %0d, trapv %0d, chk %0d, illegal %0d, other %0d",
             sb.kind_hits[EXC_NONE], sb.kind_hits[EXC_PRIVILEGE], sb.kind_hits[EXC_TRAP],
             sb.kind_hits[EXC_TRAPV], sb.kind_hits[EXC_CHK], sb.kind_hits[EXC_ILLEGAL],
             sb.kind_hits[EXC_UNKNOWN]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/csiu_pkg.sv
hw/rtl/csiu_exec.sv
hw/rtl/cpu_system_instruction_unit.sv
verif/cpu_system_instruction_unit_tb.sv
